[rtl/core/ordl_pkg.sv]
// ----------------------------------------------------------------------------
// ordl_pkg: shared types and constants of the ordered list
// Request and status codes, list sizing and the control structs that pass
// between the decoder, the cells and the top level.
// ----------------------------------------------------------------------------
package ordl_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;

  // Fixed field widths of the ports.
  localparam int REQ_W   = 2;
  localparam int POS_W   = 6;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 32;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 7;

  // Count holds 0..CAPACITY; indexes compare at the wider of count and position.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Decoder to top level: what the current request does to the row of cells.
  typedef struct packed {
    logic             do_ins;
    logic             do_rem;
    logic             rd_hit;
    logic [IDX_W-1:0] ins_pos;
    logic [IDX_W-1:0] acc_pos;
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_nxt;
  } ordl_dec_t;

  // Per-cell control for one beat.
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
    logic sel;
  } ordl_cell_ctrl_t;

endpackage

[rtl/core/ordl_cell.sv]
// ----------------------------------------------------------------------------
// ordl_cell: one slot of the ordered list
// Holds one item; loads a new item, takes its left or right neighbor, or
// holds. Drives its item onto the read bus when selected.
// ----------------------------------------------------------------------------
module ordl_cell (
  input  logic                                clk_i,
  input  ordl_pkg::ordl_cell_ctrl_t           ctrl_i,
  input  logic [ordl_pkg::ITEM_WIDTH-1:0]     new_i,
  input  logic [ordl_pkg::ITEM_WIDTH-1:0]     left_i,
  input  logic [ordl_pkg::ITEM_WIDTH-1:0]     right_i,
  output logic [ordl_pkg::ITEM_WIDTH-1:0]     data_o,
  output logic [ordl_pkg::ITEM_WIDTH-1:0]     rd_o
);
  import ordl_pkg::*;

  logic [ITEM_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = new_i;
    end else if (ctrl_i.from_left) begin
      data_d = left_i;
    end else if (ctrl_i.from_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = ctrl_i.sel ? data_q : '0;

endmodule

[rtl/core/ordl_ctrl.sv]
// ----------------------------------------------------------------------------
// ordl_ctrl: request decoder and entry counter
// Keeps the entry count, classifies each request (full, out of range) and
// resolves the effective insert position.
// ----------------------------------------------------------------------------
module ordl_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic [ordl_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ordl_pkg::POS_W-1:0]      position_i,
  output ordl_pkg::ordl_dec_t             dec_o
);
  import ordl_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] pos_x, cnt_x;
  logic             is_wr, full, oor;
  req_e             req;

  assign req   = req_e'(req_type_i);
  assign pos_x = IDX_W'(position_i);
  assign cnt_x = IDX_W'(count_q);
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign oor   = (pos_x >= cnt_x);

  always_comb begin
    is_wr         = 1'b0;
    dec_o         = '0;
    dec_o.count   = count_q;
    dec_o.acc_pos = pos_x;
    dec_o.status  = ST_OK;
    unique case (req)
      REQ_APPEND, REQ_INSERT: begin
        is_wr = 1'b1;
      end
      REQ_READ, REQ_REMOVE: begin
        is_wr = 1'b0;
      end
      default: begin
        is_wr = 1'b0;
      end
    endcase

    // Clamp to the end for append and for positions past the count.
    dec_o.ins_pos = ((req == REQ_APPEND) || (pos_x > cnt_x)) ? cnt_x : pos_x;

    if (is_wr) begin
      dec_o.status = full ? ST_FULL : ST_OK;
      dec_o.do_ins = fire_i && !full;
    end else begin
      dec_o.status = oor ? ST_RANGE : ST_OK;
      dec_o.rd_hit = !oor;
      dec_o.do_rem = fire_i && !oor && (req == REQ_REMOVE);
    end

    if (dec_o.do_ins) begin
      dec_o.count_nxt = count_q + CNT_W'(1);
    end else if (dec_o.do_rem) begin
      dec_o.count_nxt = count_q - CNT_W'(1);
    end else begin
      dec_o.count_nxt = count_q;
    end
  end

  assign count_d = dec_o.count_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[rtl/core/ordered_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_remove: fixed-capacity ordered list of item handles
// The result beat of an accepted request is registered in the output register.
// Throughput: one request per cycle; every affected cell shifts in the same cycle.
// A stalled result holds in the output register and blocks new requests.
// Reset clears the entry count and the output valid; slot contents are
// left as they are and are only read below the count.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ordl_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ordl_pkg::POS_W-1:0]      position_i,
  input  logic [ordl_pkg::IN_W-1:0]       item_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ordl_pkg::OUT_W-1:0]      item_out_o,
  output logic [ordl_pkg::STAT_W-1:0]     status_o,
  output logic [ordl_pkg::ECNT_W-1:0]     entry_count_o
);
  import ordl_pkg::*;

  logic                  fire;
  ordl_dec_t             dec;
  ordl_cell_ctrl_t       cctl  [CAPACITY];
  logic [ITEM_WIDTH-1:0] cdata [CAPACITY];
  logic [ITEM_WIDTH-1:0] crd   [CAPACITY];
  logic [ITEM_WIDTH-1:0] new_item;
  logic [ITEM_WIDTH-1:0] rd_val;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      item_out_q, item_out_d;
  status_e               status_q, status_d;
  logic [ECNT_W-1:0]     ecnt_q, ecnt_d;

  // Take a new request whenever the output register is empty or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign new_item   = ITEM_WIDTH'(item_value_i);

  ordl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_type_i (req_type_i),
    .position_i (position_i),
    .dec_o      (dec)
  );

  // Row of cells: cell i loads at the insert point, takes its left neighbor
  // above it on insert, and takes its right neighbor from the removal point on.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left, right;

    always_comb begin
      cctl[i].load       = dec.do_ins && (IDX_W'(i) == dec.ins_pos);
      cctl[i].from_left  = dec.do_ins && (IDX_W'(i) > dec.ins_pos);
      cctl[i].from_right = dec.do_rem && (IDX_W'(i) >= dec.acc_pos);
      cctl[i].sel        = (IDX_W'(i) == dec.acc_pos);
    end

    if (i == 0) begin : g_first
      assign left = cdata[i];
    end else begin : g_mid_l
      assign left = cdata[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cdata[i];
    end else begin : g_mid_r
      assign right = cdata[i+1];
    end

    ordl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cctl[i]),
      .new_i   (new_item),
      .left_i  (left),
      .right_i (right),
      .data_o  (cdata[i]),
      .rd_o    (crd[i])
    );
  end

  // At most one cell drives the read bus, so an OR merges them.
  always_comb begin
    rd_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_val = rd_val | crd[k];
    end
  end

  // Capture the result beat; the read value is taken before any shift lands.
  always_comb begin
    out_valid_d = out_valid_q;
    item_out_d  = item_out_q;
    status_d    = status_q;
    ecnt_d      = ecnt_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      item_out_d  = dec.rd_hit ? OUT_W'(rd_val) : '0;
      status_d    = dec.status;
      ecnt_d      = ECNT_W'(dec.count_nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_out_q <= item_out_d;
    status_q   <= status_d;
    ecnt_q     <= ecnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign item_out_o    = item_out_q;
  assign status_o      = status_q;
  assign entry_count_o = ecnt_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.do_ins |=> dec.count == $past(dec.count) + CNT_W'(1))
    else $error("insert did not grow the list by one");

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.do_rem |=> dec.count == $past(dec.count) - CNT_W'(1))
    else $error("remove did not shrink the list by one");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> item_out_o == '0)
    else $error("rejected request returned a nonzero item");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == ECNT_W'(CAPACITY))
    else $error("full status with list not full");
`endif

endmodule
